// File: design/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// shared widths, result codes, controller states and command/status types
// for the least-squares-count block
// ----------------------------------------------------------------------------
package msq_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int ROOT_WIDTH  = VALUE_WIDTH / 2 + 1;
	localparam int SQ_WIDTH    = 2 * ROOT_WIDTH;
	localparam int COUNT_WIDTH = 3;

	// highest power of four that fits in VALUE_WIDTH bits
	localparam int SQRT_SHIFT = 2 * ((VALUE_WIDTH - 1) / 2);
	localparam logic [VALUE_WIDTH-1:0] SQRT_BIT_START = VALUE_WIDTH'(1) << SQRT_SHIFT;

	localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO  = 3'd0;
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = 3'd1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_TWO   = 3'd2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_THREE = 3'd3;
	localparam logic [COUNT_WIDTH-1:0] COUNT_FOUR  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQRT,
		ST_SEARCH,
		ST_DONE
	} msq_state_t;

	typedef struct packed {
		logic                   load;
		logic                   strip_step;
		logic                   sqrt_init;
		logic                   sqrt_step;
		logic                   search_init;
		logic                   lo_step;
		logic                   hi_step;
		logic                   res_load;
		logic [COUNT_WIDTH-1:0] res_val;
		logic                   out_load;
	} msq_cmd_t;

	typedef struct packed {
		logic is_zero;
		logic low2_zero;
		logic is_seven;
		logic sqrt_done;
		logic lo_gt_hi;
		logic sum_eq;
		logic sum_lt;
		logic hi_zero;
		logic lo_zero;
	} msq_status_t;

endpackage

// File: design/min_square_count_four_square.sv
// ----------------------------------------------------------------------------
// min_square_count_four_square
// least number of perfect squares (1 to 4) summing to an integer, 0 for zero;
// strip factors of four, test 7 mod 8, then an exact square-pair search
// steps: s factor-of-four strips (up to 15), 16 square-root steps and k
// pair-search steps (up to about 46342 at 31 bits, one pointer move per
// cycle); a new value is taken only once the last one is done, while its
// result may still wait on the output
// reset: arst_n clears the controller and the output valid, no other state
// ----------------------------------------------------------------------------
module min_square_count_four_square (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [msq_pkg::VALUE_WIDTH-1:0]     value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [msq_pkg::COUNT_WIDTH-1:0]     square_count
);

	msq_pkg::msq_cmd_t    cmd;
	msq_pkg::msq_status_t status;

	msq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	msq_datapath u_datapath (
		.clk          (clk),
		.value        (value),
		.cmd          (cmd),
		.status       (status),
		.square_count (square_count)
	);

endmodule

// File: design/msq_datapath.sv
// ----------------------------------------------------------------------------
// msq_datapath
// factor-of-four stripping, bit-pair integer square root and the
// two-pointer square-pair search, with the result and output registers
// ----------------------------------------------------------------------------
module msq_datapath (
	input  logic                                clk,
	input  logic [msq_pkg::VALUE_WIDTH-1:0]     value,
	input  msq_pkg::msq_cmd_t                   cmd,
	output msq_pkg::msq_status_t                status,
	output logic [msq_pkg::COUNT_WIDTH-1:0]     square_count
);

	logic [msq_pkg::VALUE_WIDTH-1:0] n_q;
	logic [msq_pkg::VALUE_WIDTH-1:0] x_q;
	logic [msq_pkg::VALUE_WIDTH-1:0] root_q;
	logic [msq_pkg::VALUE_WIDTH-1:0] bit_q;
	logic [msq_pkg::ROOT_WIDTH-1:0]  lo_q;
	logic [msq_pkg::ROOT_WIDTH-1:0]  hi_q;
	logic [msq_pkg::SQ_WIDTH-1:0]    lo_sq_q;
	logic [msq_pkg::SQ_WIDTH-1:0]    hi_sq_q;
	logic [msq_pkg::COUNT_WIDTH-1:0] res_q;
	logic [msq_pkg::COUNT_WIDTH-1:0] count_q;

	logic [msq_pkg::VALUE_WIDTH:0]   trial;
	logic                            trial_fits;
	logic [msq_pkg::ROOT_WIDTH-1:0]  root_final;
	logic [msq_pkg::SQ_WIDTH-1:0]    root_sq;
	logic [msq_pkg::SQ_WIDTH:0]      pair_sum;
	logic [msq_pkg::SQ_WIDTH:0]      n_ext;

	assign trial      = {1'b0, root_q} + {1'b0, bit_q};
	assign trial_fits = {1'b0, x_q} >= trial;
	assign root_final = root_q[msq_pkg::ROOT_WIDTH-1:0];
	assign root_sq    = root_final * root_final;
	assign pair_sum   = {1'b0, lo_sq_q} + {1'b0, hi_sq_q};
	assign n_ext      = (msq_pkg::SQ_WIDTH + 1)'(n_q);

	always_comb begin
		status.is_zero   = (n_q == '0);
		status.low2_zero = (n_q[1:0] == 2'b00);
		status.is_seven  = (n_q[2:0] == 3'b111);
		status.sqrt_done = (bit_q == '0);
		status.lo_gt_hi  = (lo_q > hi_q);
		status.sum_eq    = (pair_sum == n_ext);
		status.sum_lt    = (pair_sum < n_ext);
		status.hi_zero   = (hi_q == '0);
		status.lo_zero   = (lo_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= value;
		end else if (cmd.strip_step) begin
			n_q <= n_q >> 2;
		end

		if (cmd.sqrt_init) begin
			x_q    <= n_q;
			root_q <= '0;
			bit_q  <= msq_pkg::SQRT_BIT_START;
		end else if (cmd.sqrt_step) begin
			if (trial_fits) begin
				x_q    <= x_q - trial[msq_pkg::VALUE_WIDTH-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.search_init) begin
			lo_q    <= '0;
			lo_sq_q <= '0;
			hi_q    <= root_final;
			hi_sq_q <= root_sq;
		end else begin
			if (cmd.lo_step) begin
				lo_q    <= lo_q + 1'b1;
				lo_sq_q <= lo_sq_q + msq_pkg::SQ_WIDTH'({lo_q, 1'b1});
			end
			if (cmd.hi_step) begin
				hi_q    <= hi_q - 1'b1;
				hi_sq_q <= hi_sq_q - msq_pkg::SQ_WIDTH'({hi_q, 1'b0})
					+ msq_pkg::SQ_WIDTH'(1);
			end
		end

		if (cmd.res_load) begin
			res_q <= cmd.res_val;
		end
		if (cmd.out_load) begin
			count_q <= res_q;
		end
	end

	assign square_count = count_q;

endmodule

// File: design/msq_ctrl.sv
// ----------------------------------------------------------------------------
// msq_ctrl
// controller state machine: sequences strip, square root and pair search,
// and owns the handshakes of both channels
// ----------------------------------------------------------------------------
module msq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  msq_pkg::msq_status_t status,
	output msq_pkg::msq_cmd_t    cmd
);

	msq_pkg::msq_state_t state_q;
	msq_pkg::msq_state_t state_next;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			msq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = msq_pkg::ST_CHECK;
				end
			end
			msq_pkg::ST_CHECK: begin
				if (status.is_zero || (!status.low2_zero && status.is_seven)) begin
					state_next = msq_pkg::ST_DONE;
				end else if (!status.low2_zero) begin
					state_next = msq_pkg::ST_SQRT;
				end
			end
			msq_pkg::ST_SQRT: begin
				if (status.sqrt_done) begin
					state_next = msq_pkg::ST_SEARCH;
				end
			end
			msq_pkg::ST_SEARCH: begin
				if (status.lo_gt_hi || status.sum_eq || (!status.sum_lt && status.hi_zero)) begin
					state_next = msq_pkg::ST_DONE;
				end
			end
			msq_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = msq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = msq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			msq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			msq_pkg::ST_CHECK: begin
				if (status.is_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = msq_pkg::COUNT_ZERO;
				end else if (status.low2_zero) begin
					cmd.strip_step = 1'b1;
				end else if (status.is_seven) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = msq_pkg::COUNT_FOUR;
				end else begin
					cmd.sqrt_init = 1'b1;
				end
			end
			msq_pkg::ST_SQRT: begin
				if (status.sqrt_done) begin
					cmd.search_init = 1'b1;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			msq_pkg::ST_SEARCH: begin
				if (status.lo_gt_hi) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = msq_pkg::COUNT_THREE;
				end else if (status.sum_eq) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = status.lo_zero ? msq_pkg::COUNT_ONE : msq_pkg::COUNT_TWO;
				end else if (status.sum_lt) begin
					cmd.lo_step = 1'b1;
				end else if (status.hi_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = msq_pkg::COUNT_THREE;
				end else begin
					cmd.hi_step = 1'b1;
				end
			end
			msq_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: bench/min_square_count_four_square_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_square_count_four_square_tb
// drives non-negative integers into the least-squares-count block and
// compares every square_count that comes back with a fixed table count or
// an independent two-pointer computation; a short table of directed values
// (zero, one, powers of four, 7 mod 8, the largest value) is followed by
// random values, most of them small so that the pair search stays short,
// run through phases with no idling, sender gaps, receiver stalls and both
// ----------------------------------------------------------------------------
module min_square_count_four_square_tb;

	localparam int HALF_PERIOD    = 5;
	localparam int RANDOM_ITEMS   = 25;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int PROBE_COUNT    = 20;

	typedef struct packed {
		logic [msq_pkg::VALUE_WIDTH-1:0] value;
		logic                            fixed;
		logic [msq_pkg::COUNT_WIDTH-1:0] count;
	} probe_row_t;

	typedef struct packed {
		logic [msq_pkg::VALUE_WIDTH-1:0] value;
		logic [msq_pkg::COUNT_WIDTH-1:0] count;
	} count_record_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [msq_pkg::VALUE_WIDTH-1:0] value = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [msq_pkg::COUNT_WIDTH-1:0] square_count;

	count_record_t pending_counts [$];
	count_record_t oldest;
	int            mismatch_count = 0;
	int            quiet_cycles = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;

	probe_row_t probe_rows [0:PROBE_COUNT-1] = '{
		'{msq_pkg::VALUE_WIDTH'(0),             1'b1, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(1),             1'b1, msq_pkg::COUNT_ONE},
		'{msq_pkg::VALUE_WIDTH'(2),             1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(3),             1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(4),             1'b1, msq_pkg::COUNT_ONE},
		'{msq_pkg::VALUE_WIDTH'(5),             1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(6),             1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(7),             1'b1, msq_pkg::COUNT_FOUR},
		'{msq_pkg::VALUE_WIDTH'(8),             1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(12),            1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(15),            1'b1, msq_pkg::COUNT_FOUR},
		'{msq_pkg::VALUE_WIDTH'(25),            1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(28),            1'b1, msq_pkg::COUNT_FOUR},
		'{msq_pkg::VALUE_WIDTH'(1073741824),    1'b1, msq_pkg::COUNT_ONE},
		'{msq_pkg::VALUE_WIDTH'(805306368),     1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(2147395600),    1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(2147483647),    1'b1, msq_pkg::COUNT_FOUR},
		'{msq_pkg::VALUE_WIDTH'(2147483646),    1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(32'h5555_5555), 1'b0, msq_pkg::COUNT_ZERO},
		'{msq_pkg::VALUE_WIDTH'(32'h2aaa_aaaa), 1'b0, msq_pkg::COUNT_ZERO}
	};

	min_square_count_four_square dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.square_count (square_count)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [msq_pkg::COUNT_WIDTH-1:0] least_square_count(
		input logic [msq_pkg::VALUE_WIDTH-1:0] v
	);
		longint unsigned n;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned trial;
		longint unsigned sum;
		int              b;
		n = v;
		if (n == 0) begin
			return msq_pkg::COUNT_ZERO;
		end
		while ((n & 64'd3) == 0) begin
			n = n >> 2;
		end
		if ((n & 64'd7) == 64'd7) begin
			return msq_pkg::COUNT_FOUR;
		end
		// exact floor square root, one bit at a time
		hi = 0;
		for (b = msq_pkg::ROOT_WIDTH; b >= 0; b--) begin
			trial = hi | (64'd1 << b);
			if (trial * trial <= n) begin
				hi = trial;
			end
		end
		lo = 0;
		while (lo <= hi) begin
			sum = lo * lo + hi * hi;
			if (sum == n) begin
				return (lo == 0) ? msq_pkg::COUNT_ONE : msq_pkg::COUNT_TWO;
			end
			if (sum < n) begin
				lo = lo + 1;
			end else begin
				if (hi == 0) begin
					return msq_pkg::COUNT_THREE;
				end
				hi = hi - 1;
			end
		end
		return msq_pkg::COUNT_THREE;
	endfunction

	// mostly short searches, a few across the full range
	function automatic logic [msq_pkg::VALUE_WIDTH-1:0] pick_value();
		int              kind;
		int              k;
		longint unsigned a;
		longint unsigned b;
		longint unsigned n;
		kind = $urandom_range(99);
		if (kind < 6) begin
			n = $urandom;
		end else if (kind < 36) begin
			n = $urandom_range(1, 1 << 20);
		end else if (kind < 70) begin
			n = $urandom_range(1, 1 << 12);
		end else if (kind < 82) begin
			a = $urandom_range(1, 255);
			k = $urandom_range(0, 7);
			n = (a * a) << (2 * k);
		end else if (kind < 92) begin
			a = $urandom_range(1, 1000);
			b = $urandom_range(1, 1000);
			n = a * a + b * b;
		end else begin
			a = $urandom_range(0, 1 << 19);
			k = $urandom_range(0, 4);
			n = (8 * a + 7) << (2 * k);
		end
		return msq_pkg::VALUE_WIDTH'(n);
	endfunction

	task automatic offer_value(
		input logic [msq_pkg::VALUE_WIDTH-1:0] v,
		input logic                            fixed,
		input logic [msq_pkg::COUNT_WIDTH-1:0] fixed_count
	);
		count_record_t entry;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		entry.value = v;
		entry.count = fixed ? fixed_count : least_square_count(v);
		pending_counts.push_back(entry);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_counts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual square_count %0d",
						$time, square_count);
					mismatch_count++;
				end else begin
					oldest = pending_counts.pop_front();
					if (square_count !== oldest.count) begin
						$display("%0t: value %0d, expected square_count %0d, actual %0d",
							$time, oldest.value, oldest.count, square_count);
						mismatch_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int p;
		int i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 50;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 50;
				end
				default: begin
					idle_pct  = 17;
					stall_pct = 17;
				end
			endcase
			if (p == 0) begin
				for (i = 0; i < PROBE_COUNT; i++) begin
					offer_value(probe_rows[i].value, probe_rows[i].fixed, probe_rows[i].count);
				end
			end
			for (i = 0; i < RANDOM_ITEMS; i++) begin
				offer_value(pick_value(), 1'b0, msq_pkg::COUNT_ZERO);
			end
		end
		in_valid <= 1'b0;
		while (pending_counts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: min_square_count_four_square.f
design/msq_pkg.sv
design/msq_datapath.sv
design/msq_ctrl.sv
design/min_square_count_four_square.sv
bench/min_square_count_four_square_tb.sv
